// File: design/lfd_pkg.sv
`timescale 1ns / 1ps
package lfd_pkg;

    localparam int PHASES = 48;
    localparam int TAPS   = 5;

    typedef struct packed {
        logic signed [15:0] sample_re;
        logic signed [15:0] sample_im;
        logic               last_sample;
    } lfd_in_t;

    typedef struct packed {
        logic signed [15:0] out_re;
        logic signed [15:0] out_im;
        logic               out_last;
    } lfd_out_t;

    typedef enum logic {
        ST_IDLE,
        ST_FLUSH
    } lfd_state_t;

    typedef logic signed [17:0] coeff_t;

    localparam coeff_t COEFF_ROM [0:PHASES*TAPS-1] = '{
        0, 4096, 0, 0, 0,
        -21, 4267, -171, 21, 0,
        -41, 4424, -328, 41, 0,
        -59, 4564, -468, 59, 0,
        -74, 4686, -590, 74, 0,
        -85, 4779, -683, 85, 0,
        -93, 4844, -748, 93, 0,
        -98, 4880, -784, 98, 0,
        -98, 4915, -819, 98, 0,
        -95, 4880, -784, 95, 0,
        -85, 4779, -683, 85, 0,
        -69, 4587, -491, 69, 0,
        -45, 4273, -177, 45, 0,
        11, 3819, 277, -11, 0,
        94, 3200, 896, -94, 0,
        208, 2385, 1711, -208, 0,
        352, 1344, 2752, -352, 0,
        523, 43, 4053, -523, 0,
        717, -1557, 5653, -717, 0,
        931, -3434, 7530, -931, 0,
        1163, -5557, 9653, -1163, 0,
        1408, -7936, 12032, -1408, 0,
        1664, -10587, 14683, -1664, 0,
        1927, -13483, 17579, -1927, 0,
        2193, -16597, 20693, -2193, 0,
        2458, -19904, 24000, -2458, 0,
        2715, -23381, 27477, -2715, 0,
        2960, -27001, 31097, -2960, 0,
        3189, -30741, 34837, -3189, 0,
        3397, -34575, 38671, -3397, 0,
        3577, -38477, 42573, -3577, 0,
        3728, -42421, 46517, -3728, 0,
        3844, -46379, 50475, -3844, 0,
        3920, -50322, 54418, -3920, 0,
        3952, -54225, 58321, -3952, 0,
        3936, -58060, 62156, -3936, 0,
        3869, -61390, 65536, -3869, 0,
        3744, -64178, 68608, -3744, 0,
        3557, -66395, 71360, -3557, 0,
        3304, -68010, 73760, -3304, 0,
        2980, -68992, 75776, -2980, 0,
        2580, -69312, 77824, -2580, 0,
        2100, -68936, 79456, -2100, 0,
        1534, -67832, 80640, -1534, 0,
        878, -65927, 81408, -878, 0,
        126, -63150, 81920, -126, 0,
        -744, -59427, 82016, 744, 0,
        -1781, -54690, 82144, 1781, 0
    };

    function automatic coeff_t coeff_lookup(input logic [5:0] row, input logic [2:0] k);
        int idx;
        idx = int'(row) * TAPS + int'(k);
        return COEFF_ROM[idx];
    endfunction

endpackage

// File: design/lfd_ram.sv
`timescale 1ns / 1ps
module lfd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: design/lagrange_fractional_delay_top.sv
`timescale 1ns / 1ps
// Fractional delay of one complex sample stream by a 5-tap interpolator.
// Input channel: in_valid / in_stall with an lfd_in_t item per sample; mark
// the final sample of each frame with last_sample. Output channel:
// out_valid / out_stall with an lfd_out_t item; out_last marks the final
// output of the frame. Configuration: the Q16 delay register at APB address 0,
// which the user must write only while idle; the block does not enforce it.
// Each sample from the fourth on yields one output three samples back. The
// last sample of a frame yields up to four outputs; in_stall stays high for
// the extra ones. All other items are taken one per cycle unless out_stall
// holds the pipeline. An output passes from its item through tap address,
// then the registered ring read, multiply, sum and round steps.
// The five taps are read from five copies of the sample ring, one per tap.
// When out_stall is high with a result waiting, the whole pipeline holds
// and in_stall rises. Reset clears the delay, the frame position and the
// pipeline; the ring needs no clearing pass.
module lagrange_fractional_delay_top #(
    parameter int MAX_DELAY  = 1024,
    parameter int RING_DEPTH = 2048,
    parameter int MAX_POINTS = 65536
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  lfd_pkg::lfd_in_t      in_item,
    output logic                  out_valid,
    input  logic                  out_stall,
    output lfd_pkg::lfd_out_t     out_item,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import lfd_pkg::*;

    localparam int NW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int AW   = $clog2(RING_DEPTH);
    localparam int PW   = NW + 28;
    localparam int CWID = PW - 16;
    localparam logic [26:0] DMAX = 27'(MAX_DELAY * 65536);

    logic [26:0]    delay_reg;
    lfd_state_t     state_reg, state_next;
    logic [NW-1:0]  count_reg, count_next;
    logic [AW-1:0]  wp_reg, wp_next;
    logic [NW-1:0]  flush_m_reg, flush_m_next;
    logic [NW-1:0]  flush_n_reg, flush_n_next;
    logic [AW-1:0]  flush_wp_reg, flush_wp_next;

    logic           adv, acc, is_last;
    logic           job_go, job_last, job_fwd;
    logic [NW-1:0]  job_m, job_n, m0;
    logic [AW-1:0]  job_wp;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {5'b0, delay_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= '0;
        end
        else if (psel && penable && pwrite && paddr[2] == 1'b0)
        begin
            delay_reg <= pwdata[26:0];
        end
    end

    // job sequencer
    assign adv     = !out_valid || !out_stall;
    assign acc     = in_valid && !in_stall;
    assign is_last = in_item.last_sample || (count_reg == NW'(MAX_POINTS - 1));
    assign m0      = (count_reg >= NW'(3)) ? count_reg - NW'(3) : '0;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc && is_last && m0 != count_reg)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (adv && flush_m_reg == flush_n_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall      = !adv;
        job_go        = 1'b0;
        job_m         = m0;
        job_n         = count_reg;
        job_wp        = wp_reg;
        job_last      = 1'b0;
        job_fwd       = 1'b0;
        count_next    = count_reg;
        wp_next       = wp_reg;
        flush_m_next  = flush_m_reg;
        flush_n_next  = flush_n_reg;
        flush_wp_next = flush_wp_reg;
        case (state_reg)
            ST_IDLE:
            begin
                job_go   = acc && (is_last || count_reg >= NW'(3));
                job_last = is_last && (m0 == count_reg);
                job_fwd  = 1'b1;
                if (acc)
                begin
                    if (is_last)
                    begin
                        count_next    = '0;
                        wp_next       = '0;
                        flush_m_next  = m0 + NW'(1);
                        flush_n_next  = count_reg;
                        flush_wp_next = wp_reg;
                    end
                    else
                    begin
                        count_next = count_reg + NW'(1);
                        wp_next    = (wp_reg == AW'(RING_DEPTH - 1)) ? '0 : wp_reg + AW'(1);
                    end
                end
            end
            ST_FLUSH:
            begin
                in_stall = 1'b1;
                job_go   = adv;
                job_m    = flush_m_reg;
                job_n    = flush_n_reg;
                job_wp   = flush_wp_reg;
                job_last = (flush_m_reg == flush_n_reg);
                if (adv)
                begin
                    flush_m_next = flush_m_reg + NW'(1);
                end
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            wp_reg       <= '0;
            flush_m_reg  <= '0;
            flush_n_reg  <= '0;
            flush_wp_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            wp_reg       <= wp_next;
            flush_m_reg  <= flush_m_next;
            flush_n_reg  <= flush_n_next;
            flush_wp_reg <= flush_wp_next;
        end
    end

    // tap addresses
    logic [26:0]            dcl;
    logic signed [PW-1:0]   pos;
    logic signed [CWID-1:0] center;
    logic signed [CWID-1:0] n_ext;
    logic [15:0]            frac;
    logic [17:0]            frac3;
    logic [5:0]             row;
    logic signed [CWID-1:0] idx  [TAPS];
    logic [CWID-1:0]        lag  [TAPS];
    logic [AW:0]            atmp [TAPS];
    logic [AW-1:0]          raddr [TAPS];
    logic [TAPS-1:0]        tvalid, tfwd;

    always_comb
    begin
        dcl    = (delay_reg > DMAX) ? DMAX : delay_reg;
        pos    = $signed({{(PW-NW-16){1'b0}}, job_m, 16'b0})
               - $signed({{(PW-27){1'b0}}, dcl});
        center = pos[PW-1:16];
        frac   = pos[15:0];
        frac3  = {2'b0, frac} + {1'b0, frac, 1'b0};
        row    = frac3[17:12];
        n_ext  = $signed({{(CWID-NW){1'b0}}, job_n});
        for (int k = 0; k < TAPS; k++)
        begin
            idx[k]    = center - CWID'(1) + CWID'(k);
            tvalid[k] = !pos[PW-1] && !idx[k][CWID-1] && (idx[k] <= n_ext);
            tfwd[k]   = job_fwd && (idx[k] == n_ext);
            lag[k]    = n_ext - idx[k];
            atmp[k]   = {1'b0, job_wp} - {1'b0, lag[k][AW-1:0]};
            if (atmp[k][AW])
            begin
                atmp[k] = atmp[k] + (AW+1)'(RING_DEPTH);
            end
            raddr[k]  = atmp[k][AW-1:0];
        end
    end

    // sample ring, one copy per tap
    logic [31:0] rdata [TAPS];

    for (genvar g = 0; g < TAPS; g++)
    begin : g_ring
        lfd_ram #(
            .WIDTH (32),
            .DEPTH (RING_DEPTH)
        ) u_ring (
            .clk   (clk),
            .we    (acc),
            .waddr (wp_reg),
            .wdata ({in_item.sample_re, in_item.sample_im}),
            .re    (adv),
            .raddr (raddr[g]),
            .rdata (rdata[g])
        );
    end

    // stage B: ring data ready
    logic            vb_reg;
    logic            lastb_reg;
    logic [5:0]      rowb_reg;
    logic [TAPS-1:0] maskb_reg, fwdb_reg;
    logic [31:0]     fwds_reg;

    // stage C: products
    logic               vc_reg, lastc_reg;
    logic signed [33:0] pre_reg [TAPS];
    logic signed [33:0] pim_reg [TAPS];
    logic signed [33:0] pre_next [TAPS];
    logic signed [33:0] pim_next [TAPS];

    // stage D: sums
    logic               vd_reg, lastd_reg;
    logic signed [36:0] sre_reg, sim_reg, sre_next, sim_next;

    logic               out_valid_reg;
    lfd_out_t           out_item_reg, out_item_next;

    always_comb
    begin
        logic [31:0]        d;
        logic signed [15:0] dre, dim;
        coeff_t             c;
        for (int k = 0; k < TAPS; k++)
        begin
            d   = fwdb_reg[k] ? fwds_reg : rdata[k];
            dre = maskb_reg[k] ? $signed(d[31:16]) : 16'sd0;
            dim = maskb_reg[k] ? $signed(d[15:0]) : 16'sd0;
            c   = coeff_lookup(rowb_reg, 3'(k));
            pre_next[k] = dre * c;
            pim_next[k] = dim * c;
        end
    end

    always_comb
    begin
        sre_next = 37'(pre_reg[0]) + 37'(pre_reg[1]) + 37'(pre_reg[2])
                 + 37'(pre_reg[3]) + 37'(pre_reg[4]);
        sim_next = 37'(pim_reg[0]) + 37'(pim_reg[1]) + 37'(pim_reg[2])
                 + 37'(pim_reg[3]) + 37'(pim_reg[4]);
    end

    function automatic logic signed [15:0] round_sat(input logic signed [36:0] a);
        logic signed [37:0] r;
        logic signed [25:0] q;
        r = 38'(a) + 38'sd2048;
        q = 26'(r >>> 12);
        if (q > 26'sd32767)
        begin
            return 16'sd32767;
        end
        else if (q < -26'sd32768)
        begin
            return -16'sd32768;
        end
        return q[15:0];
    endfunction

    always_comb
    begin
        out_item_next.out_re   = round_sat(sre_reg);
        out_item_next.out_im   = round_sat(sim_reg);
        out_item_next.out_last = lastd_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg        <= 1'b0;
            vc_reg        <= 1'b0;
            vd_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vb_reg        <= job_go;
            vc_reg        <= vb_reg;
            vd_reg        <= vc_reg;
            out_valid_reg <= vd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lastb_reg    <= job_last;
            rowb_reg     <= row;
            maskb_reg    <= tvalid;
            fwdb_reg     <= tfwd;
            fwds_reg     <= {in_item.sample_re, in_item.sample_im};
            lastc_reg    <= lastb_reg;
            pre_reg      <= pre_next;
            pim_reg      <= pim_next;
            lastd_reg    <= lastc_reg;
            sre_reg      <= sre_next;
            sim_reg      <= sim_next;
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        acc |-> state_reg == ST_IDLE)
        else $error("item accepted during flush");

    a_flush_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FLUSH |-> flush_m_reg <= flush_n_reg)
        else $error("flush ran past last output");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NW'(MAX_POINTS - 1))
        else $error("frame position out of range");

    a_flush_holds_in: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FLUSH |-> in_stall)
        else $error("input open during flush");

endmodule
